// ===== rtl/tbd_pkg.sv =====
// shared types and constants of the touch baseline detector
`timescale 1ns / 1ps

package tbd_pkg;

    localparam int SAMPLE_W = 8;
    localparam int SQUARE_W = 16;
    localparam int VAR_W    = 16;
    localparam int THRESH_W = 17;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = 8'd255;
    localparam logic [SAMPLE_W-1:0] MARGIN_RESET = 8'd5;

    // one entry of the short window: the sample and its square
    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [SQUARE_W-1:0] square;
    } tbd_cell_t;

endpackage

// ===== rtl/tbd_cell.sv =====
// one cell of the short window shift chain
`timescale 1ns / 1ps

module tbd_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  tbd_pkg::tbd_cell_t  din,
    output tbd_pkg::tbd_cell_t  dout
);
    import tbd_pkg::*;

    tbd_cell_t entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (shift)
        begin
            entry_reg <= din;
        end
    end

    assign dout = entry_reg;

endmodule

// ===== rtl/tbd_const_div.sv =====
// division by a constant through a scaled reciprocal multiply
`timescale 1ns / 1ps

module tbd_const_div #(
    parameter int DIVISOR = 4,
    parameter int IN_W    = 12,
    parameter int OUT_W   = 8
) (
    input  logic [IN_W-1:0]  din,
    output logic [OUT_W-1:0] quo
);
    localparam int SHIFT = IN_W + $clog2(DIVISOR);
    localparam int MW    = IN_W + 2;
    localparam int PW    = IN_W + MW;
    localparam logic [63:0] RECIP = ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

    logic [PW-1:0] prod;

    assign prod = PW'(din) * PW'(RECIP[MW-1:0]);
    assign quo  = OUT_W'(prod >> SHIFT);

endmodule

// ===== rtl/tbd_long_window.sv =====
// long boxcar: sample ring in memory with running sum
`timescale 1ns / 1ps

module tbd_long_window #(
    parameter int DEPTH = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    input  logic [tbd_pkg::SAMPLE_W-1:0]       sample,
    output logic [$clog2(DEPTH*255+1)-1:0]     total
);
    import tbd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int TW = $clog2(DEPTH*255+1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [AW-1:0]       pos_reg;
    logic [AW-1:0]       pos_next;
    logic [AW-1:0]       rd_addr;
    logic                filled_reg;
    logic [TW-1:0]       total_reg;
    logic [TW-1:0]       total_next;
    logic [SAMPLE_W-1:0] oldest;

    assign pos_next   = (pos_reg == LAST) ? '0 : pos_reg + 1'b1;
    assign rd_addr    = push ? pos_next : pos_reg;
    // entries not yet written since reset read as zero
    assign oldest     = filled_reg ? rd_data_reg : '0;
    assign total_next = total_reg - TW'(oldest) + TW'(sample);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[pos_reg] <= sample;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            filled_reg <= 1'b0;
            total_reg  <= '0;
        end
        else if (push)
        begin
            pos_reg   <= pos_next;
            total_reg <= total_next;
            if (pos_reg == LAST)
            begin
                filled_reg <= 1'b1;
            end
        end
    end

    assign total = total_reg;

endmodule

// ===== rtl/touch_baseline_detector.sv =====
// top level of the touch baseline detector
//
// usage:
//   s_tdata carries one raw touch conversion per request; the block inverts
//   it, feeds a SHORT_DEPTH-cell shift chain and a LONG_DEPTH-entry ring
//   memory, and returns one result request per input request on m_tdata.
//   cfg_wr_en/cfg_wr_data write touch_margin (reset value 5); the user must do so
//   only while idle; the block itself does not enforce it.
//   throughput: one request per cycle while the receiver does not stall, set
//   by the six-stage pipeline that advances as a whole; the ring memory takes one
//   write per accepted request and one prefetch read of the next position each cycle.
//   reset clears both windows, the touch flag and the pipeline valid flags; the
//   long ring needs no clearing pass, unwritten entries read as zero until the
//   write position first wraps.
//   when the receiver stalls with a result held in the output register,
//   the whole pipeline and s_tready hold; no request is lost.
`timescale 1ns / 1ps

module touch_baseline_detector #(
    parameter int SHORT_DEPTH = 4,
    parameter int LONG_DEPTH  = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // raw_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,      // sample_value, long_average, short_average,
                                      // short_variance, touched, touch_event, zero fill
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data   // touch_margin
);
    import tbd_pkg::*;

    localparam int SW  = $clog2(SHORT_DEPTH*255+1);
    localparam int SQW = $clog2(SHORT_DEPTH*65025+1);
    localparam int LW  = $clog2(LONG_DEPTH*255+1);
    localparam int XW  = SQW + 1;
    localparam int TW  = SAMPLE_W + SW;

    logic en;
    logic accept;
    logic [SAMPLE_W-1:0] sample;
    logic [SQUARE_W-1:0] sample_sq;

    tbd_cell_t link [SHORT_DEPTH+1];

    logic [SW-1:0]  short_total_reg;
    logic [SW-1:0]  short_total_next;
    logic [SQW-1:0] sumsq_reg;
    logic [SQW-1:0] sumsq_next;
    logic [LW-1:0]  long_total;
    logic [SAMPLE_W-1:0] margin_reg;

    logic                v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic [SAMPLE_W-1:0] a_sample_reg;

    logic [SAMPLE_W-1:0] b_sample_reg, b_savg_reg, b_lavg_reg;
    logic [SW-1:0]       b_tot_reg;
    logic [SQW-1:0]      b_sumsq_reg;
    logic [SAMPLE_W-1:0] savg_q, lavg_q;

    logic [SAMPLE_W-1:0] c_sample_reg, c_savg_reg, c_lavg_reg;
    logic [SQW-1:0]      c_sumsq_reg;
    logic [SQUARE_W-1:0] c_asq_reg;
    logic [TW-1:0]       c_atot_reg;

    logic [SAMPLE_W-1:0] d_sample_reg, d_savg_reg, d_lavg_reg;
    logic [SQW-1:0]      d_ssd_reg;
    logic [XW-1:0]       ssd_wide;

    logic [SAMPLE_W-1:0] e_sample_reg, e_savg_reg, e_lavg_reg;
    logic [VAR_W-1:0]    e_var_reg;
    logic [VAR_W-1:0]    var_q;

    logic [THRESH_W-1:0] thresh;
    logic                touched;
    logic                touch_flag_reg;
    logic [47:0]         out_data_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    assign sample    = SAMPLE_MAX - s_tdata;
    assign sample_sq = SQUARE_W'(sample) * SQUARE_W'(sample);

    // short window chain, newest entry in the first cell
    assign link[0] = {sample, sample_sq};

    for (genvar i = 0; i < SHORT_DEPTH; i++)
    begin : g_cell
        tbd_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (accept),
            .din   (link[i]),
            .dout  (link[i+1])
        );
    end

    assign short_total_next = short_total_reg - SW'(link[SHORT_DEPTH].value) + SW'(sample);
    assign sumsq_next       = sumsq_reg - SQW'(link[SHORT_DEPTH].square) + SQW'(sample_sq);

    tbd_long_window #(
        .DEPTH (LONG_DEPTH)
    ) u_long (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (accept),
        .sample (sample),
        .total  (long_total)
    );

    tbd_const_div #(
        .DIVISOR (SHORT_DEPTH),
        .IN_W    (SW),
        .OUT_W   (SAMPLE_W)
    ) u_short_div (
        .din (short_total_reg),
        .quo (savg_q)
    );

    tbd_const_div #(
        .DIVISOR (LONG_DEPTH),
        .IN_W    (LW),
        .OUT_W   (SAMPLE_W)
    ) u_long_div (
        .din (long_total),
        .quo (lavg_q)
    );

    tbd_const_div #(
        .DIVISOR (SHORT_DEPTH),
        .IN_W    (SQW),
        .OUT_W   (VAR_W)
    ) u_var_div (
        .din (d_ssd_reg),
        .quo (var_q)
    );

    // sum of squared deviations: sumsq + n*a^2 - 2*a*total
    assign ssd_wide = XW'(c_sumsq_reg) + XW'(c_asq_reg) * XW'(SHORT_DEPTH)
                    - (XW'(c_atot_reg) << 1);

    assign thresh  = THRESH_W'(e_lavg_reg) + THRESH_W'(e_var_reg) + THRESH_W'(margin_reg);
    assign touched = THRESH_W'(e_savg_reg) > thresh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= MARGIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            margin_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_total_reg <= '0;
            sumsq_reg       <= '0;
        end
        else if (accept)
        begin
            short_total_reg <= short_total_next;
            sumsq_reg       <= sumsq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg         <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            touch_flag_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg        <= s_tvalid;
            v1_reg        <= v0_reg;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
            if (v4_reg)
            begin
                touch_flag_reg <= touched;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_sample_reg <= sample;

            b_sample_reg <= a_sample_reg;
            b_savg_reg   <= savg_q;
            b_lavg_reg   <= lavg_q;
            b_tot_reg    <= short_total_reg;
            b_sumsq_reg  <= sumsq_reg;

            c_sample_reg <= b_sample_reg;
            c_savg_reg   <= b_savg_reg;
            c_lavg_reg   <= b_lavg_reg;
            c_sumsq_reg  <= b_sumsq_reg;
            c_asq_reg    <= SQUARE_W'(b_savg_reg) * SQUARE_W'(b_savg_reg);
            c_atot_reg   <= TW'(b_savg_reg) * TW'(b_tot_reg);

            d_sample_reg <= c_sample_reg;
            d_savg_reg   <= c_savg_reg;
            d_lavg_reg   <= c_lavg_reg;
            d_ssd_reg    <= ssd_wide[SQW-1:0];

            e_sample_reg <= d_sample_reg;
            e_savg_reg   <= d_savg_reg;
            e_lavg_reg   <= d_lavg_reg;
            e_var_reg    <= var_q;

            out_data_reg <= {6'd0, touched && !touch_flag_reg, touched, e_var_reg,
                             e_savg_reg, e_lavg_reg, e_sample_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
